// ===== design/lkvc_pkg.sv =====
`timescale 1ns / 1ps
package lkvc_pkg;

	localparam int unsigned DEF_CACHE_ENTRIES = 16;

	localparam int unsigned OP_W    = 2;
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned STAMP_W = 31;
	localparam int unsigned SLOT_W  = 4;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture request, clear scan trackers
		logic rd_en;   // read entry at scan address, advance address
		logic commit;  // write back entry and load result register
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_addr;
	} dp_status_t;

endpackage

// ===== design/lkvc_req_if.sv =====
`timescale 1ns / 1ps
interface lkvc_req_if;
	logic                                valid;
	logic                                ready;
	logic [lkvc_pkg::OP_W-1:0]           op;
	logic signed [lkvc_pkg::KEY_W-1:0]   req_key;
	logic signed [lkvc_pkg::VAL_W-1:0]   write_value;
	logic [lkvc_pkg::STAMP_W-1:0]        use_stamp;

	modport source (output valid, op, req_key, write_value, use_stamp, input ready);
	modport sink (input valid, op, req_key, write_value, use_stamp, output ready);
endinterface

// ===== design/lkvc_rsp_if.sv =====
`timescale 1ns / 1ps
interface lkvc_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                hit;
	logic signed [lkvc_pkg::VAL_W-1:0]   read_value;
	logic [lkvc_pkg::SLOT_W-1:0]         slot;

	modport source (output valid, hit, read_value, slot, input ready);
	modport sink (input valid, hit, read_value, slot, output ready);
endinterface

// ===== design/lkvc_ctrl.sv =====
`timescale 1ns / 1ps
module lkvc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output lkvc_pkg::ctrl_cmd_t    cmd,
	input  lkvc_pkg::dp_status_t   status
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.rd_en  = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (status.last_addr) begin
					state_d = ST_DRAIN;
				end
			end
			// last compare lands here
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/lkvc_datapath.sv =====
`timescale 1ns / 1ps
module lkvc_datapath #(
	parameter int unsigned CACHE_ENTRIES = lkvc_pkg::DEF_CACHE_ENTRIES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lkvc_pkg::ctrl_cmd_t                  cmd,
	output lkvc_pkg::dp_status_t                 status,
	input  logic [lkvc_pkg::OP_W-1:0]            op,
	input  logic [lkvc_pkg::KEY_W-1:0]           req_key,
	input  logic [lkvc_pkg::VAL_W-1:0]           write_value,
	input  logic [lkvc_pkg::STAMP_W-1:0]         use_stamp,
	output logic                                 hit,
	output logic [lkvc_pkg::VAL_W-1:0]           read_value,
	output logic [lkvc_pkg::SLOT_W-1:0]          slot
);

	localparam int unsigned IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

	// entry store, one read and one write port
	lkvc_pkg::entry_t entry_mem [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] valid_q;

	// captured request
	logic [lkvc_pkg::OP_W-1:0]    op_q;
	logic [lkvc_pkg::KEY_W-1:0]   key_q;
	logic [lkvc_pkg::VAL_W-1:0]   wval_q;
	logic [lkvc_pkg::STAMP_W-1:0] stamp_q;

	// scan
	logic [IW-1:0]          addr_q;
	lkvc_pkg::entry_t       rd_data_s1;
	logic                   cmp_valid_s1;
	logic [IW-1:0]          cmp_idx_s1;

	// trackers
	logic                         hit_q;
	logic [IW-1:0]                hit_idx_q;
	logic [lkvc_pkg::VAL_W-1:0]   hit_val_q;
	logic                         empty_found_q;
	logic [IW-1:0]                empty_idx_q;
	logic [IW-1:0]                min_idx_q;
	logic [lkvc_pkg::STAMP_W-1:0] min_stamp_q;

	// result register
	logic                         res_hit_q;
	logic [lkvc_pkg::VAL_W-1:0]   res_val_q;
	logic [lkvc_pkg::SLOT_W-1:0]  res_slot_q;

	logic                   cmp_vld_entry;
	logic                   cmp_match;
	logic                   op_known;
	logic [IW-1:0]          victim_idx;
	logic                   wr_en;
	logic                   set_valid;
	logic [IW-1:0]          wr_idx;
	lkvc_pkg::entry_t       wr_data;

	assign status.last_addr = (addr_q == LAST_IDX);

	assign cmp_vld_entry = valid_q[cmp_idx_s1];
	assign cmp_match     = cmp_vld_entry && (rd_data_s1.key == key_q);

	assign op_known   = (op_q == lkvc_pkg::OP_LOOKUP) || (op_q == lkvc_pkg::OP_INSERT)
			|| (op_q == lkvc_pkg::OP_UPDATE);
	assign victim_idx = empty_found_q ? empty_idx_q : min_idx_q;

	always_comb begin
		wr_en         = 1'b0;
		set_valid     = 1'b0;
		wr_idx        = victim_idx;
		wr_data.key   = key_q;
		wr_data.value = wval_q;
		wr_data.stamp = stamp_q;
		if (cmd.commit && op_known) begin
			if (hit_q) begin
				wr_en  = 1'b1;
				wr_idx = hit_idx_q;
				if (op_q == lkvc_pkg::OP_LOOKUP) begin
					wr_data.value = hit_val_q;
				end
			end else if (op_q == lkvc_pkg::OP_INSERT) begin
				wr_en     = 1'b1;
				set_valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_idx] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= entry_mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			cmp_valid_s1 <= 1'b0;
			addr_q       <= '0;
		end else begin
			cmp_valid_s1 <= cmd.rd_en;
			if (cmd.load) begin
				addr_q <= '0;
			end else if (cmd.rd_en) begin
				addr_q <= addr_q + 1'b1;
			end
			if (set_valid) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			cmp_idx_s1 <= addr_q;
		end
		if (cmd.load) begin
			op_q          <= op;
			key_q         <= req_key;
			wval_q        <= write_value;
			stamp_q       <= use_stamp;
			hit_q         <= 1'b0;
			empty_found_q <= 1'b0;
			min_idx_q     <= '0;
			min_stamp_q   <= '1;
		end else if (cmp_valid_s1) begin
			// lowest index wins on match, empty slot and equal stamps
			if (cmp_match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= cmp_idx_s1;
				hit_val_q <= rd_data_s1.value;
			end
			if (!cmp_vld_entry && !empty_found_q) begin
				empty_found_q <= 1'b1;
				empty_idx_q   <= cmp_idx_s1;
			end
			if (cmp_vld_entry && (rd_data_s1.stamp < min_stamp_q)) begin
				min_stamp_q <= rd_data_s1.stamp;
				min_idx_q   <= cmp_idx_s1;
			end
		end
		if (cmd.commit) begin
			res_hit_q  <= 1'b0;
			res_val_q  <= '0;
			res_slot_q <= '0;
			if (op_known && hit_q) begin
				res_hit_q  <= 1'b1;
				res_val_q  <= hit_val_q;
				res_slot_q <= lkvc_pkg::SLOT_W'(hit_idx_q);
			end else if (op_q == lkvc_pkg::OP_INSERT) begin
				res_slot_q <= lkvc_pkg::SLOT_W'(victim_idx);
			end
		end
	end

	assign hit        = res_hit_q;
	assign read_value = res_val_q;
	assign slot       = res_slot_q;

endmodule

// ===== design/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// lru_key_value_cache: fully associative key-value cache with lru replacement
// by caller stamps, CACHE_ENTRIES entries.
// req channel: one beat per request (op, req_key, write_value, use_stamp).
// rsp channel: exactly one beat per request (hit, read_value, slot), in order.
// each request scans the entry memory one entry per cycle through its single
// read port, then writes back through the single write port. the response
// is registered at write-back, and the next request is taken only after
// the current one has written back.
// req.ready is high only while no request is in work; a request may be taken
// while the previous response still waits in the output register.
// if rsp.ready stays low, the next request finishes its scan and then holds
// until the waiting response is taken, so nothing is dropped or reordered.
// reset clears all valid bits at once; no clearing pass is needed, and entry
// contents are undefined until written.
module lru_key_value_cache #(
	parameter int unsigned CACHE_ENTRIES = lkvc_pkg::DEF_CACHE_ENTRIES
) (
	input  logic       clk,
	input  logic       arst_n,
	lkvc_req_if.sink   req,
	lkvc_rsp_if.source rsp
);

	lkvc_pkg::ctrl_cmd_t  cmd;
	lkvc_pkg::dp_status_t status;

	lkvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.status    (status)
	);

	lkvc_datapath #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.op          (req.op),
		.req_key     (req.req_key),
		.write_value (req.write_value),
		.use_stamp   (req.use_stamp),
		.hit         (rsp.hit),
		.read_value  (rsp.read_value),
		.slot        (rsp.slot)
	);

endmodule

// ===== design/lkvc_checker.sv =====
`timescale 1ns / 1ps
module lkvc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic                               rsp_hit,
	input logic [lkvc_pkg::VAL_W-1:0]         rsp_read_value
);

	// response beat holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped before beat");

	// a miss never reports a value
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_read_value == '0)
		else $error("miss with nonzero read_value");

	// one request in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while scan busy");

	// a response never rises directly after its request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_valid && req_ready))
		else $error("response too early after request");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_hit        (rsp.hit),
	.rsp_read_value (rsp.read_value)
);
